FILE: sv/ebs_pkg.sv
// ----------------------------------------------------------------------------
// ebs_pkg: shared definitions for the exponential search block
// Store geometry, operation codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ebs_pkg;

  localparam int STORE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int COUNT_W     = ADDR_W + 1;
  // probe index reaches just below 2*2^ADDR_W, exclusive bound one more
  localparam int IDX_W       = ADDR_W + 2;
  localparam int DATA_W      = 32;
  localparam int POS_W       = 10;
  localparam int OPC_W       = 2;

  typedef enum logic [OPC_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_SEARCH = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROBE,
    ST_PROBE_WAIT,
    ST_BIN,
    ST_BIN_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clear;
    logic append;
    logic search;
    logic probe_rd;
    logic probe_step;
    logic bin_init;
    logic bin_rd;
    logic bin_lo;
    logic bin_hi;
    logic bin_cut;
    logic res_set;
    logic res_found;
    logic res_from_mid;
    logic load_rsp;
  } ebs_cmd_t;

  typedef struct packed {
    logic empty;
    logic hi_in;
    logic mid_in;
    logic bin_open;
    logic cmp_lt;
    logic cmp_eq;
    logic rsp_busy;
  } ebs_sts_t;

endpackage

FILE: sv/ebs_req_if.sv
// ----------------------------------------------------------------------------
// ebs_req_if: request channel
// Operation code and operand with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface ebs_req_if;
  logic                              valid;
  logic                              ready;
  logic [ebs_pkg::OPC_W-1:0]         opcode;
  logic signed [ebs_pkg::DATA_W-1:0] value;

  modport source(output valid, output opcode, output value, input ready);
  modport sink(input valid, input opcode, input value, output ready);
endinterface

FILE: sv/ebs_rsp_if.sv
// ----------------------------------------------------------------------------
// ebs_rsp_if: response channel
// Search outcome with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface ebs_rsp_if;
  logic                      valid;
  logic                      ready;
  logic                      found;
  logic [ebs_pkg::POS_W-1:0] position;

  modport source(output valid, output found, output position, input ready);
  modport sink(input valid, input found, input position, output ready);
endinterface

FILE: sv/exponential_binary_search.sv
// Clear and append update the fill count straight from ST_IDLE. A search spends
// a read state and a compare state on each store read (registered RAM read, then
// compare), probe reads first, then bisection reads; an empty store skips both.
// One transaction at a time, paced by the RAM reads; a pending response holds it.
// Reset clears the fill count and controller; store contents stay undefined
// (no clearing pass), entries past the fill count are never read.
// ----------------------------------------------------------------------------
// exponential_binary_search: sorted store with exponential search
// Append/clear/search requests; each search returns found and position.
// ----------------------------------------------------------------------------
module exponential_binary_search (
  input logic         clk,
  input logic         rst,
  ebs_req_if.sink     req,
  ebs_rsp_if.source   rsp
);

  ebs_pkg::ebs_cmd_t cmd;
  ebs_pkg::ebs_sts_t sts;

  ebs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req.valid),
    .opcode   (req.opcode),
    .req_ready(req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ebs_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .value    (req.value),
    .rsp_ready(rsp.ready),
    .rsp_valid(rsp.valid),
    .rsp_found(rsp.found),
    .rsp_pos  (rsp.position)
  );

endmodule

FILE: sv/ebs_ram.sv
// ----------------------------------------------------------------------------
// ebs_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module ebs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/ebs_dpath.sv
// ----------------------------------------------------------------------------
// ebs_dpath: exponential search datapath
// Store RAM, fill count, probe bracket, bisection bounds, key compare
// and the response register.
// ----------------------------------------------------------------------------
module ebs_dpath (
  input  logic                              clk,
  input  logic                              rst,
  input  ebs_pkg::ebs_cmd_t                 cmd,
  output ebs_pkg::ebs_sts_t                 sts,
  input  logic signed [ebs_pkg::DATA_W-1:0] value,
  input  logic                              rsp_ready,
  output logic                              rsp_valid,
  output logic                              rsp_found,
  output logic [ebs_pkg::POS_W-1:0]         rsp_pos
);

  logic [ebs_pkg::COUNT_W-1:0]       fill_count;
  logic signed [ebs_pkg::DATA_W-1:0] key;
  logic [ebs_pkg::IDX_W-1:0]         lo;
  logic [ebs_pkg::IDX_W-1:0]         hi;
  logic [ebs_pkg::IDX_W-1:0]         l;
  logic [ebs_pkg::IDX_W-1:0]         r_ex;   // exclusive upper bound
  logic [ebs_pkg::IDX_W-1:0]         mid;
  logic [ebs_pkg::IDX_W-1:0]         mid_calc;
  logic [ebs_pkg::IDX_W-1:0]         fill_ext;
  logic [ebs_pkg::IDX_W-1:0]         hit_idx;
  logic                              res_found;
  logic [ebs_pkg::POS_W-1:0]         res_pos;
  logic                              full;
  logic                              wr_en;
  logic [ebs_pkg::ADDR_W-1:0]        raddr;
  logic [ebs_pkg::DATA_W-1:0]        rdata;
  logic signed [ebs_pkg::DATA_W-1:0] entry;

  assign fill_ext = ebs_pkg::IDX_W'(fill_count);
  assign full     = (fill_count == ebs_pkg::COUNT_W'(ebs_pkg::STORE_DEPTH));
  assign wr_en    = cmd.append && !full;
  assign mid_calc = l + ((r_ex - l - ebs_pkg::IDX_W'(1)) >> 1);
  assign raddr    = cmd.probe_rd ? hi[ebs_pkg::ADDR_W-1:0] : mid_calc[ebs_pkg::ADDR_W-1:0];
  assign entry    = $signed(rdata);
  assign hit_idx  = cmd.res_from_mid ? mid : hi;

  ebs_ram #(
    .WIDTH(ebs_pkg::DATA_W),
    .DEPTH(ebs_pkg::STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (wr_en),
    .waddr(fill_count[ebs_pkg::ADDR_W-1:0]),
    .wdata(value),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (cmd.clear) begin
      fill_count <= '0;
    end else if (wr_en) begin
      fill_count <= fill_count + ebs_pkg::COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lo <= '0;
      hi <= '0;
    end else if (cmd.search) begin
      lo <= '0;
      hi <= '0;
    end else if (cmd.probe_step) begin
      lo <= hi;
      hi <= {hi[ebs_pkg::IDX_W-2:0], 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.search) begin
      key <= value;
    end
    if (cmd.bin_init) begin
      l    <= lo;
      r_ex <= hi + ebs_pkg::IDX_W'(1);
    end else if (cmd.bin_lo) begin
      l <= mid + ebs_pkg::IDX_W'(1);
    end else if (cmd.bin_hi) begin
      r_ex <= mid;
    end else if (cmd.bin_cut) begin
      r_ex <= mid_calc;
    end
    if (cmd.bin_rd) begin
      mid <= mid_calc;
    end
    if (cmd.res_set) begin
      res_found <= cmd.res_found;
      res_pos   <= cmd.res_found ? hit_idx[ebs_pkg::POS_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_rsp) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_rsp) begin
      rsp_found <= res_found;
      rsp_pos   <= res_pos;
    end
  end

  always_comb begin
    sts.empty    = (fill_count == '0);
    sts.hi_in    = (hi < fill_ext);
    sts.mid_in   = (mid_calc < fill_ext);
    sts.bin_open = (l < r_ex);
    sts.cmp_lt   = (entry < key);
    sts.cmp_eq   = (entry == key);
    sts.rsp_busy = rsp_valid && !rsp_ready;
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= ebs_pkg::COUNT_W'(ebs_pkg::STORE_DEPTH))
    else $error("fill count beyond store depth");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.probe_rd || cmd.bin_rd) |-> (raddr < fill_ext[ebs_pkg::ADDR_W-1:0] ||
                                      fill_ext > ebs_pkg::IDX_W'(raddr)))
    else $error("store read beyond fill count");

  a_hit_valid: assert property (@(posedge clk) disable iff (rst)
    (cmd.res_set && cmd.res_found) |-> hit_idx < fill_ext)
    else $error("hit index outside filled range");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_found) |-> rsp_pos == '0)
    else $error("miss carries nonzero position");

endmodule

FILE: sv/ebs_ctrl.sv
// ----------------------------------------------------------------------------
// ebs_ctrl: exponential search controller
// Sequences the doubling probe, the bisection and the response handoff.
// ----------------------------------------------------------------------------
module ebs_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  input  logic [ebs_pkg::OPC_W-1:0] opcode,
  output logic                      req_ready,
  input  ebs_pkg::ebs_sts_t         sts,
  output ebs_pkg::ebs_cmd_t         cmd
);

  ebs_pkg::state_t state;
  ebs_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ebs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      ebs_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          case (opcode)
            ebs_pkg::OP_CLEAR: begin
              cmd.clear = 1'b1;
            end
            ebs_pkg::OP_APPEND: begin
              cmd.append = 1'b1;
            end
            ebs_pkg::OP_SEARCH: begin
              cmd.search = 1'b1;
              if (sts.empty) begin
                cmd.res_set = 1'b1;
                state_next  = ebs_pkg::ST_DONE;
              end else begin
                state_next = ebs_pkg::ST_PROBE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ebs_pkg::ST_PROBE: begin
        // slots past the fill count rank above any key
        if (sts.hi_in) begin
          cmd.probe_rd = 1'b1;
          state_next   = ebs_pkg::ST_PROBE_WAIT;
        end else begin
          cmd.bin_init = 1'b1;
          state_next   = ebs_pkg::ST_BIN;
        end
      end
      ebs_pkg::ST_PROBE_WAIT: begin
        if (sts.cmp_lt) begin
          cmd.probe_step = 1'b1;
          state_next     = ebs_pkg::ST_PROBE;
        end else if (sts.cmp_eq) begin
          cmd.res_set   = 1'b1;
          cmd.res_found = 1'b1;
          state_next    = ebs_pkg::ST_DONE;
        end else begin
          cmd.bin_init = 1'b1;
          state_next   = ebs_pkg::ST_BIN;
        end
      end
      ebs_pkg::ST_BIN: begin
        if (!sts.bin_open) begin
          cmd.res_set = 1'b1;
          state_next  = ebs_pkg::ST_DONE;
        end else if (sts.mid_in) begin
          cmd.bin_rd = 1'b1;
          state_next = ebs_pkg::ST_BIN_WAIT;
        end else begin
          cmd.bin_cut = 1'b1;
        end
      end
      ebs_pkg::ST_BIN_WAIT: begin
        if (sts.cmp_lt) begin
          cmd.bin_lo = 1'b1;
          state_next = ebs_pkg::ST_BIN;
        end else if (sts.cmp_eq) begin
          cmd.res_set      = 1'b1;
          cmd.res_found    = 1'b1;
          cmd.res_from_mid = 1'b1;
          state_next       = ebs_pkg::ST_DONE;
        end else begin
          cmd.bin_hi = 1'b1;
          state_next = ebs_pkg::ST_BIN;
        end
      end
      ebs_pkg::ST_DONE: begin
        if (!sts.rsp_busy) begin
          cmd.load_rsp = 1'b1;
          state_next   = ebs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ebs_pkg::ST_IDLE;
      end
    endcase
  end

  a_probe_wait_order: assert property (@(posedge clk) disable iff (rst)
    state == ebs_pkg::ST_PROBE_WAIT |-> $past(state) == ebs_pkg::ST_PROBE)
    else $error("probe compare without a preceding read");

  a_bin_wait_order: assert property (@(posedge clk) disable iff (rst)
    state == ebs_pkg::ST_BIN_WAIT |-> $past(state) == ebs_pkg::ST_BIN)
    else $error("bisection compare without a preceding read");

  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.load_rsp |-> !sts.rsp_busy)
    else $error("response overwritten while pending");

endmodule
